// ===== rtl/ihv_pkg.sv =====
// Shared types and constants for the IPv4 header validator.
// Used by the front, queue, back and top-level modules; no dependencies.
`default_nettype none

package ihv_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [15:0] CountMax  = 16'hFFFF;
  localparam logic [15:0] PadLimit  = 16'd46;
  localparam logic [15:0] MinHeader = 16'd20;
  localparam logic [15:0] SumGood   = 16'hFFFF;
  localparam logic [3:0]  IpVersion = 4'd4;
  localparam logic [3:0]  MinIhl    = 4'd5;

  localparam logic [15:0] IdxTotalHi = 16'd2;
  localparam logic [15:0] IdxTotalLo = 16'd3;
  localparam logic [15:0] IdxFragHi  = 16'd6;
  localparam logic [15:0] IdxFragLo  = 16'd7;
  localparam logic [15:0] IdxTtl     = 16'd8;
  localparam logic [15:0] IdxProto   = 16'd9;
  localparam logic [15:0] IdxDstLo   = 16'd16;
  localparam logic [15:0] IdxDstHi   = 16'd19;
  localparam logic [15:0] IdxPadMin  = 16'd4;

  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 32;

  typedef enum logic [CfgIndexW-1:0] {
    RegLocalAddress = 2'd0,
    RegFragAllowedA = 2'd1,
    RegFragAllowedB = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    StDeliver  = 3'd0,
    StForward  = 3'd1,
    StChecksum = 3'd2,
    StVersion  = 3'd3,
    StIhl      = 3'd4,
    StLength   = 3'd5,
    StFragment = 3'd6,
    StTtl      = 3'd7
  } status_t;

  // Everything the back end needs about one finished frame.
  typedef struct packed {
    logic [15:0] frame_len;
    logic [15:0] hdr_sum;
    logic [7:0]  version_ihl;
    logic [15:0] total_length;
    logic [15:0] fragment_word;
    logic [7:0]  time_to_live;
    logic [7:0]  protocol;
    logic [31:0] destination;
    logic [15:0] pad_zero_count;
  } frame_sum_t;

endpackage

`default_nettype wire

// ===== rtl/ipv4_header_validator_top.sv =====
// Top level of the IPv4 header validator.
// Instantiates ihv_front, ihv_queue and ihv_back; uses ihv_pkg.
`default_nettype none

// Takes one datagram byte per cycle while in_stall is low, with last_byte on
// the final byte, and gives one result item per frame: status, protocol and
// payload_length. The per-byte work is a single ones' complement add and field
// capture, so unstalled input runs at one byte per clock with no gaps between
// frames. The edge that accepts the last byte writes the frame queue; the
// output register loads the result from it when empty or not stalled.
// in_stall rises only when the queue (QUEUE_DEPTH frames) is full behind a
// stalled output. Configuration registers are written through cfg_write,
// cfg_index and cfg_data and take effect on results graded after the write.
module ipv4_header_validator_top #(
  parameter int unsigned QUEUE_DEPTH = ihv_pkg::QueueDepth
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [ihv_pkg::CfgIndexW-1:0]  cfg_index,
  input  wire logic [ihv_pkg::CfgDataW-1:0]   cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [7:0]                     data_byte,
  input  wire logic                           last_byte,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [2:0]                          status,
  output logic [7:0]                          protocol,
  output logic [15:0]                         payload_length
);
  import ihv_pkg::*;

  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_not_empty;
  frame_sum_t q_push_data;
  frame_sum_t q_head;

  ihv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_push_data)
  );

  ihv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  ihv_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .q_not_empty    (q_not_empty),
    .q_head         (q_head),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .protocol       (protocol),
    .payload_length (payload_length)
  );

endmodule

`default_nettype wire

// ===== rtl/ihv_front.sv =====
// Front end: takes datagram bytes, sums header words and captures fields.
// On the final byte it pushes a frame summary into the queue. Uses ihv_pkg.
`default_nettype none

module ihv_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        data_byte,
  input  wire logic              last_byte,
  input  wire logic              q_full,
  output logic                   push,
  output ihv_pkg::frame_sum_t    push_data
);
  import ihv_pkg::*;

  logic [15:0] byte_count;
  logic [15:0] sum_acc;
  logic [7:0]  high_byte_hold;
  logic [7:0]  version_ihl;
  logic [15:0] total_length;
  logic [15:0] fragment_word;
  logic [7:0]  time_to_live;
  logic [7:0]  protocol_hold;
  logic [31:0] destination;
  logic [15:0] pad_zero_count;

  logic [15:0] byte_count_next;
  logic [15:0] sum_acc_next;
  logic [7:0]  high_byte_hold_next;
  logic [7:0]  version_ihl_next;
  logic [15:0] total_length_next;
  logic [15:0] fragment_word_next;
  logic [7:0]  time_to_live_next;
  logic [7:0]  protocol_hold_next;
  logic [31:0] destination_next;
  logic [15:0] pad_zero_count_next;

  logic        accept;
  logic [5:0]  hdr_len;
  logic [16:0] raw_sum;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign push     = accept && last_byte;

  always_comb begin
    version_ihl_next    = (byte_count == 16'd0) ? data_byte : version_ihl;
    hdr_len             = {version_ihl_next[3:0], 2'b00};
    high_byte_hold_next = high_byte_hold;
    sum_acc_next        = sum_acc;
    raw_sum             = {1'b0, sum_acc} + {1'b0, high_byte_hold, data_byte};
    if (byte_count < {10'd0, hdr_len}) begin
      if (!byte_count[0]) begin
        high_byte_hold_next = data_byte;
      end else begin
        // end-around carry
        sum_acc_next = raw_sum[15:0] + {15'd0, raw_sum[16]};
      end
    end

    total_length_next  = total_length;
    fragment_word_next = fragment_word;
    time_to_live_next  = time_to_live;
    protocol_hold_next = protocol_hold;
    destination_next   = destination;
    case (byte_count)
      IdxTotalHi: total_length_next  = {data_byte, total_length[7:0]};
      IdxTotalLo: total_length_next  = {total_length[15:8], data_byte};
      IdxFragHi:  fragment_word_next = {data_byte, fragment_word[7:0]};
      IdxFragLo:  fragment_word_next = {fragment_word[15:8], data_byte};
      IdxTtl:     time_to_live_next  = data_byte;
      IdxProto:   protocol_hold_next = data_byte;
      default: begin
        if (byte_count >= IdxDstLo && byte_count <= IdxDstHi) begin
          destination_next = {destination[23:0], data_byte};
        end
      end
    endcase

    pad_zero_count_next = pad_zero_count;
    if (byte_count >= IdxPadMin && byte_count >= total_length &&
        data_byte == 8'd0 && pad_zero_count != CountMax) begin
      pad_zero_count_next = pad_zero_count + 16'd1;
    end

    byte_count_next = (byte_count != CountMax) ? byte_count + 16'd1 : byte_count;

    push_data.frame_len      = byte_count_next;
    push_data.hdr_sum        = sum_acc_next;
    push_data.version_ihl    = version_ihl_next;
    push_data.total_length   = total_length_next;
    push_data.fragment_word  = fragment_word_next;
    push_data.time_to_live   = time_to_live_next;
    push_data.protocol       = protocol_hold_next;
    push_data.destination    = destination_next;
    push_data.pad_zero_count = pad_zero_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      byte_count     <= '0;
      sum_acc        <= '0;
      high_byte_hold <= '0;
      version_ihl    <= '0;
      total_length   <= '0;
      fragment_word  <= '0;
      time_to_live   <= '0;
      protocol_hold  <= '0;
      destination    <= '0;
      pad_zero_count <= '0;
    end else if (accept) begin
      byte_count     <= byte_count_next;
      sum_acc        <= sum_acc_next;
      high_byte_hold <= high_byte_hold_next;
      version_ihl    <= version_ihl_next;
      total_length   <= total_length_next;
      fragment_word  <= fragment_word_next;
      time_to_live   <= time_to_live_next;
      protocol_hold  <= protocol_hold_next;
      destination    <= destination_next;
      pad_zero_count <= pad_zero_count_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ihv_queue.sv =====
// Short queue of frame summaries between the front and back ends.
// Register-based ring with a fill count. Uses ihv_pkg.
`default_nettype none

module ihv_queue #(
  parameter int unsigned DEPTH = ihv_pkg::QueueDepth
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire ihv_pkg::frame_sum_t  push_data,
  output logic                      full,
  input  wire logic                 pop,
  output logic                      not_empty,
  output ihv_pkg::frame_sum_t       head
);
  import ihv_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  frame_sum_t      entries [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full      = (count == CntW'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ihv_back.sv =====
// Back end: holds the configuration registers, grades a frame summary and
// keeps the result in an output register. Uses ihv_pkg.
`default_nettype none

module ihv_back (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [ihv_pkg::CfgIndexW-1:0]    cfg_index,
  input  wire logic [ihv_pkg::CfgDataW-1:0]     cfg_data,
  input  wire logic                             q_not_empty,
  input  wire ihv_pkg::frame_sum_t              q_head,
  output logic                                  pop,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [2:0]                            status,
  output logic [7:0]                            protocol,
  output logic [15:0]                           payload_length
);
  import ihv_pkg::*;

  logic [31:0] local_address;
  logic [15:0] frag_allowed_a;
  logic [15:0] frag_allowed_b;

  status_t     verdict;
  logic [15:0] hdr_len;
  logic [15:0] eff_len;
  logic [15:0] payload;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_address  <= '0;
      frag_allowed_a <= '0;
      frag_allowed_b <= 16'h4000;
    end else if (cfg_write) begin
      case (cfg_index)
        RegLocalAddress: local_address  <= cfg_data;
        RegFragAllowedA: frag_allowed_a <= cfg_data[15:0];
        RegFragAllowedB: frag_allowed_b <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    hdr_len = {10'd0, q_head.version_ihl[3:0], 2'b00};
    eff_len = (q_head.frame_len <= PadLimit) ?
              q_head.frame_len - q_head.pad_zero_count : q_head.frame_len;
    payload = (q_head.total_length >= MinHeader) ? q_head.total_length - MinHeader : '0;

    if (q_head.frame_len < MinHeader || q_head.frame_len < hdr_len ||
        q_head.hdr_sum != SumGood) begin
      verdict = StChecksum;
    end else if (q_head.version_ihl[7:4] != IpVersion) begin
      verdict = StVersion;
    end else if (q_head.version_ihl[3:0] < MinIhl) begin
      verdict = StIhl;
    end else if (q_head.frame_len == CountMax || eff_len != q_head.total_length) begin
      verdict = StLength;
    end else if (q_head.fragment_word != frag_allowed_a &&
                 q_head.fragment_word != frag_allowed_b) begin
      verdict = StFragment;
    end else if (q_head.time_to_live == 8'd0) begin
      verdict = StTtl;
    end else if (q_head.destination != local_address) begin
      verdict = StForward;
    end else begin
      verdict = StDeliver;
    end
  end

  assign pop = q_not_empty && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status         <= verdict;
      protocol       <= q_head.protocol;
      payload_length <= payload;
    end
  end

endmodule

`default_nettype wire

// ===== bench/ipv4_header_validator_top_test.sv =====
// Self-checking bench for ipv4_header_validator_top: streams IPv4 frames byte by byte
// and checks each verdict item against a known row's values or a cycle-free predictor
// of the header checks. Depends on ihv_pkg and the RTL under rtl/.
module ipv4_header_validator_top_test;
  import ihv_pkg::*;

  localparam int TotalOfs   = 2;
  localparam int FragOfs    = 6;
  localparam int TtlOfs     = 8;
  localparam int ProtoOfs   = 9;
  localparam int SumOfs     = 10;
  localparam int DstOfs     = 16;
  localparam int PadFromOfs = 4;
  localparam int PadMaxLen  = 46;
  localparam int MinLen     = 20;
  localparam logic [15:0] CountTop = 16'hFFFF;
  localparam logic [3:0]  V4       = 4'd4;
  localparam logic [3:0]  IhlMin   = 4'd5;

  typedef struct packed {
    status_t     st;
    logic [7:0]  proto;
    logic [15:0] plen;
  } verdict_t;

  // One frame to send; st/plen are only used where known is set.
  typedef struct packed {
    logic [7:0]  vihl;
    logic [15:0] total;
    logic [15:0] frag;
    logic [7:0]  ttl;
    logic [7:0]  proto;
    logic [31:0] dst;
    logic [16:0] nbytes;
    logic        bad_sum;
    logic        junk;
    logic        noise;
    logic        known;
    status_t     st;
    logic [15:0] plen;
  } frame_row_t;

  // vihl, total, frag, ttl, proto, dst, nbytes, bad_sum, junk, noise, known, status, payload
  localparam frame_row_t DirRows [23] = '{
    '{8'h45, 16'd20, 16'h0000, 8'd64, 8'd0, 32'h0, 17'd1, 1'b0, 1'b0, 1'b0, 1'b1,
      StChecksum, 16'd0},
    '{8'h45, 16'd20, 16'h0000, 8'd64, 8'd6, 32'h0, 17'd20, 1'b0, 1'b0, 1'b0, 1'b1,
      StDeliver, 16'd0},
    '{8'h45, 16'd20, 16'h0000, 8'd64, 8'd17, 32'hC0A80001, 17'd20, 1'b0, 1'b0, 1'b0, 1'b1,
      StForward, 16'd0},
    '{8'h45, 16'd20, 16'h0000, 8'd64, 8'd17, 32'h0, 17'd20, 1'b1, 1'b0, 1'b0, 1'b1,
      StChecksum, 16'd0},
    '{8'h65, 16'd20, 16'h0000, 8'd64, 8'd1, 32'h0, 17'd20, 1'b0, 1'b0, 1'b0, 1'b1,
      StVersion, 16'd0},
    '{8'h44, 16'd20, 16'h0000, 8'd64, 8'd1, 32'h0, 17'd20, 1'b0, 1'b0, 1'b0, 1'b1,
      StIhl, 16'd0},
    '{8'h40, 16'd20, 16'h0000, 8'd64, 8'd1, 32'h0, 17'd20, 1'b0, 1'b0, 1'b0, 1'b1,
      StChecksum, 16'd0},
    '{8'h45, 16'd40, 16'h0000, 8'd64, 8'd6, 32'h0, 17'd20, 1'b0, 1'b0, 1'b0, 1'b1,
      StLength, 16'd20},
    '{8'h45, 16'd20, 16'h2000, 8'd64, 8'd6, 32'h0, 17'd20, 1'b0, 1'b0, 1'b0, 1'b1,
      StFragment, 16'd0},
    '{8'h45, 16'd20, 16'h4000, 8'd1, 8'd6, 32'h0, 17'd20, 1'b0, 1'b0, 1'b0, 1'b1,
      StDeliver, 16'd0},
    '{8'h45, 16'd20, 16'h0000, 8'd0, 8'd6, 32'h0, 17'd20, 1'b0, 1'b0, 1'b0, 1'b1,
      StTtl, 16'd0},
    '{8'h45, 16'd20, 16'h0000, 8'd64, 8'd6, 32'h0, 17'd46, 1'b0, 1'b0, 1'b0, 1'b1,
      StDeliver, 16'd0},
    '{8'h45, 16'd20, 16'h0000, 8'd64, 8'd6, 32'h0, 17'd46, 1'b0, 1'b1, 1'b0, 1'b1,
      StLength, 16'd0},
    '{8'h45, 16'd20, 16'h0000, 8'd64, 8'd6, 32'h0, 17'd47, 1'b0, 1'b0, 1'b0, 1'b1,
      StLength, 16'd0},
    '{8'h4F, 16'd60, 16'h0000, 8'd64, 8'd6, 32'h0, 17'd60, 1'b0, 1'b0, 1'b0, 1'b1,
      StDeliver, 16'd40},
    '{8'h4F, 16'd40, 16'h0000, 8'd64, 8'd6, 32'h0, 17'd40, 1'b0, 1'b0, 1'b0, 1'b1,
      StChecksum, 16'd20},
    '{8'h45, 16'hFFFF, 16'h0000, 8'd64, 8'd6, 32'h0, 17'd20, 1'b0, 1'b0, 1'b0, 1'b1,
      StLength, 16'hFFEB},
    '{8'h45, 16'd20, 16'h0000, 8'd64, 8'd6, 32'h0, 17'd19, 1'b0, 1'b0, 1'b0, 1'b1,
      StChecksum, 16'd0},
    '{8'h45, 16'd10, 16'h0000, 8'd64, 8'd6, 32'h0, 17'd20, 1'b0, 1'b0, 1'b0, 1'b0,
      StDeliver, 16'd0},
    '{8'h45, 16'd24, 16'h0000, 8'd64, 8'd6, 32'h0, 17'd46, 1'b0, 1'b0, 1'b0, 1'b0,
      StDeliver, 16'd0},
    '{8'h46, 16'd24, 16'h4000, 8'd255, 8'd255, 32'hFFFFFFFF, 17'd24, 1'b0, 1'b0, 1'b0, 1'b0,
      StDeliver, 16'd0},
    '{8'hFF, 16'h0000, 16'hFFFF, 8'd255, 8'd255, 32'hFFFFFFFF, 17'd20, 1'b0, 1'b0, 1'b0,
      1'b0, StDeliver, 16'd0},
    '{8'h00, 16'h0000, 16'h0000, 8'd0, 8'd0, 32'h0, 17'd7, 1'b0, 1'b0, 1'b1, 1'b0,
      StDeliver, 16'd0}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           data_byte = 8'h00;
  logic                 last_byte = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [2:0]           status;
  logic [7:0]           protocol;
  logic [15:0]          payload_length;

  ipv4_header_validator_top i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .last_byte      (last_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .protocol       (protocol),
    .payload_length (payload_length)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #8000000;
    $display("tb: failure");
    $finish;
  end

  // Mirror of the registers and of the per-frame capture state.
  logic [31:0] c_local  = 32'h0;
  logic [15:0] c_frag_a = 16'h0000;
  logic [15:0] c_frag_b = 16'h4000;

  logic [15:0] p_count, p_total, p_frag, p_pad;
  logic [16:0] p_sum;
  logic [7:0]  p_hi, p_vihl, p_ttl, p_proto;
  logic [31:0] p_dst;

  verdict_t    verdict_q [$];
  logic [7:0]  frame_bytes [$];
  int unsigned fail_count = 0;
  bit          send_idle = 1'b1;
  bit          recv_idle = 1'b1;
  int unsigned hold_req = 0;

  function automatic void clear_frame_state();
    p_count = '0;
    p_sum   = '0;
    p_hi    = '0;
    p_vihl  = '0;
    p_total = '0;
    p_frag  = '0;
    p_ttl   = '0;
    p_proto = '0;
    p_dst   = '0;
    p_pad   = '0;
  endfunction

  function automatic bit grade_byte(input logic [7:0] b, input logic l, output verdict_t v);
    logic [15:0] i;
    logic [5:0]  hdr;
    logic [15:0] flen, elen;
    i = p_count;
    if (i == 0) p_vihl = b;
    hdr = {p_vihl[3:0], 2'b00};
    if (i < hdr) begin
      if (!i[0]) begin
        p_hi = b;
      end else begin
        p_sum = p_sum + {p_hi, b};
        p_sum = {1'b0, p_sum[15:0]} + p_sum[16];
      end
    end
    case (i)
      TotalOfs:     p_total[15:8] = b;
      TotalOfs + 1: p_total[7:0] = b;
      FragOfs:      p_frag[15:8] = b;
      FragOfs + 1:  p_frag[7:0] = b;
      TtlOfs:       p_ttl = b;
      ProtoOfs:     p_proto = b;
      DstOfs, DstOfs + 1, DstOfs + 2, DstOfs + 3: p_dst = {p_dst[23:0], b};
      default: ;
    endcase
    if (i >= PadFromOfs && i >= p_total && b == 8'h00 && p_pad != CountTop) p_pad++;
    if (p_count != CountTop) p_count++;
    if (!l) return 1'b0;
    flen = p_count;
    elen = flen;
    if (flen <= PadMaxLen) elen = flen - p_pad;
    if (flen < MinLen || flen < hdr || p_sum != 17'h0FFFF) v.st = StChecksum;
    else if (p_vihl[7:4] != V4) v.st = StVersion;
    else if (p_vihl[3:0] < IhlMin) v.st = StIhl;
    else if (flen == CountTop || elen != p_total) v.st = StLength;
    else if (p_frag != c_frag_a && p_frag != c_frag_b) v.st = StFragment;
    else if (p_ttl == 8'h00) v.st = StTtl;
    else if (p_dst != c_local) v.st = StForward;
    else v.st = StDeliver;
    v.proto = p_proto;
    v.plen = (p_total >= MinLen) ? 16'(p_total - MinLen) : 16'h0000;
    clear_frame_state();
    return 1'b1;
  endfunction

  initial clear_frame_state();

  // Fills frame_bytes: header fields, valid checksum unless told otherwise, zero padding.
  function automatic void build_frame(input frame_row_t r);
    int unsigned hdr, body, span, j, k;
    logic [16:0] s;
    logic [15:0] ck;
    frame_bytes.delete();
    hdr = r.vihl[3:0] * 4;
    body = (hdr > MinLen) ? hdr : MinLen;
    span = (r.nbytes > body) ? r.nbytes : body;
    for (j = 0; j < span; j++) begin
      if (r.noise || j < body || j < r.total) frame_bytes.push_back(8'($urandom_range(0, 255)));
      else frame_bytes.push_back(8'h00);
    end
    if (!r.noise) begin
      frame_bytes[0] = r.vihl;
      frame_bytes[TotalOfs] = r.total[15:8];
      frame_bytes[TotalOfs + 1] = r.total[7:0];
      frame_bytes[FragOfs] = r.frag[15:8];
      frame_bytes[FragOfs + 1] = r.frag[7:0];
      frame_bytes[TtlOfs] = r.ttl;
      frame_bytes[ProtoOfs] = r.proto;
      frame_bytes[SumOfs] = 8'h00;
      frame_bytes[SumOfs + 1] = 8'h00;
      for (j = 0; j < 4; j++) frame_bytes[DstOfs + j] = r.dst[31 - 8*j -: 8];
      if (hdr >= SumOfs + 2) begin
        s = '0;
        for (k = 0; k < hdr; k += 2) begin
          s = s + {frame_bytes[k], frame_bytes[k+1]};
          s = {1'b0, s[15:0]} + s[16];
        end
        ck = ~s[15:0];
        if (r.bad_sum) ck = ck ^ 16'h0001;
        frame_bytes[SumOfs] = ck[15:8];
        frame_bytes[SumOfs + 1] = ck[7:0];
      end
      if (r.junk) begin
        j = (body > r.total) ? body : r.total;
        if (j < r.nbytes) frame_bytes[j] = 8'($urandom_range(1, 255));
      end
    end
  endfunction

  function automatic frame_row_t random_frame();
    frame_row_t r;
    int unsigned kind, ihl, plen, tot, n;
    r = '0;
    kind = $urandom_range(0, 99);
    if (kind >= 88) begin
      r.noise = 1'b1;
      r.nbytes = 17'($urandom_range(1, 30));
      return r;
    end
    ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : 5;
    plen = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
    tot = ihl * 4 + plen;
    r.vihl = {V4, ihl[3:0]};
    if ($urandom_range(0, 19) == 0) r.vihl[7:4] = 4'($urandom_range(0, 15));
    if (kind >= 75) r.vihl[3:0] = 4'($urandom_range(0, 15));
    r.total = 16'(tot);
    if ($urandom_range(0, 29) == 0) r.total = 16'($urandom_range(0, 65535));
    case ($urandom_range(0, 3))
      0: r.frag = c_frag_a;
      1: r.frag = c_frag_b;
      2: r.frag = 16'($urandom_range(0, 65535));
      default: r.frag = c_frag_b ^ (16'h0001 << $urandom_range(0, 15));
    endcase
    r.ttl = ($urandom_range(0, 12) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
    r.proto = 8'($urandom_range(0, 255));
    r.dst = $urandom_range(0, 1) ? c_local : $urandom;
    n = tot;
    if (tot < PadMaxLen && $urandom_range(0, 3) == 0) n = $urandom_range(tot, PadMaxLen);
    else if ($urandom_range(0, 14) == 0) n = tot + $urandom_range(1, 3);
    if (kind >= 75) n = $urandom_range(1, n);
    r.bad_sum = ($urandom_range(0, 19) == 0);
    r.junk = (n > tot) && ($urandom_range(0, 4) == 0);
    r.nbytes = 17'(n);
    return r;
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic l, output bit got,
                           output verdict_t v);
    while (send_idle && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    last_byte <= l;
    do @(posedge clk); while (in_stall !== 1'b0);
    got = grade_byte(b, l, v);
  endtask

  task automatic send_frame(input frame_row_t r);
    verdict_t v;
    bit got;
    int unsigned j;
    build_frame(r);
    for (j = 0; j < r.nbytes; j++) begin
      push_byte(frame_bytes[j], j == r.nbytes - 1, got, v);
      if (got) begin
        if (r.known) begin
          v.st = r.st;
          v.proto = r.proto;
          v.plen = r.plen;
        end
        verdict_q.push_back(v);
      end
    end
  endtask

  task automatic run_random(input int unsigned min_bytes, input int unsigned min_frames);
    int unsigned nb, nf;
    frame_row_t r;
    nb = 0;
    nf = 0;
    while (nb < min_bytes || nf < min_frames) begin
      r = random_frame();
      send_frame(r);
      nb += r.nbytes;
      nf++;
    end
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] addr, input logic [15:0] fa,
                            input logic [15:0] fb);
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= RegLocalAddress;
    cfg_data <= addr;
    @(posedge clk);
    cfg_index <= RegFragAllowedA;
    cfg_data <= {16'h0000, fa};
    @(posedge clk);
    cfg_index <= RegFragAllowedB;
    cfg_data <= {16'h0000, fb};
    @(posedge clk);
    cfg_write <= 1'b0;
    c_local = addr;
    c_frag_a = fa;
    c_frag_b = fb;
  endtask

  // Result side: check accepted items, then pick next cycle's stall.
  initial begin
    verdict_t e;
    logic stall_now;
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
        if (verdict_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected item: status %0d protocol %0h payload_length %0h",
                     status, protocol, payload_length);
          fail_count++;
        end else begin
          e = verdict_q.pop_front();
          if (status !== e.st || protocol !== e.proto || payload_length !== e.plen) begin
            if (fail_count < 10)
              $display("mismatch: status %0d/%0d protocol %0h/%0h payload_length %0h/%0h",
                       e.st, status, e.proto, protocol, e.plen, payload_length);
            fail_count++;
          end
        end
      end
      if (hold_left > 0) begin
        stall_now = 1'b1;
        hold_left--;
      end else if (hold_req > 0) begin
        hold_left = hold_req - 1;
        hold_req = 0;
        stall_now = 1'b1;
      end else begin
        stall_now = recv_idle && ($urandom_range(0, 99) < 25);
      end
      out_stall <= stall_now;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (DirRows[k]) send_frame(DirRows[k]);
    quiesce();

    set_config(32'hFFFFFFFF, 16'hFFFF, 16'h0000);
    run_random(0, 1);
    // long output hold-off with the sender running flat out
    hold_req = 100;
    send_idle = 1'b0;
    repeat (4) send_frame(random_frame());
    send_idle = 1'b1;
    quiesce();

    set_config($urandom, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    send_idle = 1'b0;
    recv_idle = 1'b0;
    run_random(0, 4);
    send_idle = 1'b1;
    recv_idle = 1'b1;
    quiesce();

    set_config($urandom, 16'h0000, 16'h4000);
    run_random(0, 1);
    quiesce();

    set_config(32'h00000000, 16'h4000, 16'($urandom_range(0, 65535)));
    run_random(0, 2);
    quiesce();
    repeat (16) @(posedge clk);

    if (fail_count == 0 && verdict_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
